// ----- rtl/core/rpa_pkg.sv -----
// Shared types, constants and tables of the rose path two-link arm solver.
`default_nettype none
package rpa_pkg;

  localparam int ANGLE_FRAC_BITS = 6;
  localparam int ANG_SHIFT       = 16 - ANGLE_FRAC_BITS;
  localparam int KTH_SHIFT       = 12 + ANGLE_FRAC_BITS - 16;
  localparam int CORDIC_STEPS    = 16;

  localparam logic [16:0] PHASE_WRAP = 17'(720 << ANGLE_FRAC_BITS);

  localparam logic signed [31:0] FULL_TURN    = 32'sd23592960;
  localparam logic signed [31:0] HALF_TURN    = 32'sd11796480;
  localparam logic signed [31:0] QUARTER_TURN = 32'sd5898240;
  localparam logic signed [31:0] GAIN_INV     = 32'sd652032874;
  localparam logic [30:0]        ONE_Q30      = 31'd1073741824;

  typedef enum logic [2:0] {
    CFG_CENTRE_X   = 3'd0,
    CFG_CENTRE_Y   = 3'd1,
    CFG_UPPER_LINK = 3'd2,
    CFG_LOWER_LINK = 3'd3,
    CFG_PETAL_AMP  = 3'd4,
    CFG_PETAL_K    = 3'd5,
    CFG_PHASE_STEP = 3'd6
  } rpa_cfg_idx_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_KMUL, ST_KRED0, ST_KRED,
    ST_TRIG1, ST_TRIG1W, ST_TRIG2, ST_TRIG2W,
    ST_M_AMP, ST_M_X, ST_M_XC, ST_M_YS, ST_M_XX, ST_M_YY, ST_M_L1, ST_M_L2,
    ST_SQ1, ST_SQ1W, ST_M_DEN, ST_DEN, ST_CMP, ST_DIVW,
    ST_M_QQ, ST_SQ2, ST_SQ2W, ST_AT1, ST_AT1W, ST_AT2, ST_AT2W,
    ST_TRIG3, ST_TRIG3W, ST_M_EX, ST_M_EY, ST_EYC, ST_AT3, ST_AT3W, ST_DONE
  } rpa_state_t;

  typedef enum logic [1:0] {CD_IDLE, CD_NORM, CD_ITER, CD_DONE} rpa_cd_state_t;
  typedef enum logic [1:0] {SD_IDLE, SD_RUN, SD_DONE} rpa_sd_state_t;

  typedef struct packed {
    logic start;
    logic vec;
  } rpa_cd_ctl_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } rpa_sd_ctl_t;

  // arctan(2^-i) in 2^-16 degree
  function automatic logic [21:0] atan_step(input logic [3:0] i);
    logic [21:0] t;
    unique case (i)
      4'd0:  t = 22'd2949120;
      4'd1:  t = 22'd1740967;
      4'd2:  t = 22'd919879;
      4'd3:  t = 22'd466945;
      4'd4:  t = 22'd234379;
      4'd5:  t = 22'd117305;
      4'd6:  t = 22'd58666;
      4'd7:  t = 22'd29335;
      4'd8:  t = 22'd14668;
      4'd9:  t = 22'd7334;
      4'd10: t = 22'd3667;
      4'd11: t = 22'd1833;
      4'd12: t = 22'd917;
      4'd13: t = 22'd458;
      4'd14: t = 22'd229;
      4'd15: t = 22'd115;
      default: t = 22'd0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/rpa_mul.sv -----
// Shared signed 32 x 32 multiplier with registered product.
`default_nettype none
module rpa_mul (
  input  wire logic               clk,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic signed [63:0]      p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule
`default_nettype wire

// ----- rtl/core/rpa_cordic.sv -----
// Iterative CORDIC unit: rotation for cosine/sine, vectoring for atan2.
`default_nettype none
module rpa_cordic (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rpa_pkg::rpa_cd_ctl_t ctl,
  input  wire logic signed [49:0] x_in,
  input  wire logic signed [49:0] y_in,
  input  wire logic signed [31:0] z_in,
  output logic                    done,
  output logic signed [31:0]      cos_out,
  output logic signed [31:0]      sin_out,
  output logic signed [31:0]      ang_out
);

  rpa_pkg::rpa_cd_state_t state_r, state_nxt;
  logic signed [49:0] x_r, y_r, mx_r;
  logic signed [31:0] z_r, base_r;
  logic               flip_r, vec_r;
  logic [3:0]         i_r;

  logic               triv;
  logic signed [49:0] ax_in, ay_in, mx_in, xs, ys, xneg, yneg;
  logic               norm_lo, norm_hi, turn_neg;
  logic signed [31:0] tstep, z1;

  assign triv  = ctl.vec && (y_in == '0 || x_in == '0);
  assign ax_in = x_in[49] ? -x_in : x_in;
  assign ay_in = y_in[49] ? -y_in : y_in;
  assign mx_in = (ax_in > ay_in) ? ax_in : ay_in;
  // track the scale on its own so odd negative values do not skew the stop test
  assign norm_lo = mx_r < (50'sd1 <<< 30);
  assign norm_hi = mx_r >= (50'sd1 <<< 31);
  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign turn_neg = vec_r ? (y_r > 0) : z_r[31];
  assign tstep = 32'(rpa_pkg::atan_step(i_r));
  assign z1 = (z_in > rpa_pkg::HALF_TURN) ? z_in - rpa_pkg::FULL_TURN : z_in;
  assign xneg = -x_r;
  assign yneg = -y_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rpa_pkg::CD_IDLE: begin
        if (ctl.start) begin
          if (triv) state_nxt = rpa_pkg::CD_DONE;
          else if (ctl.vec) state_nxt = rpa_pkg::CD_NORM;
          else state_nxt = rpa_pkg::CD_ITER;
        end
      end
      rpa_pkg::CD_NORM: if (!norm_lo && !norm_hi) state_nxt = rpa_pkg::CD_ITER;
      rpa_pkg::CD_ITER: if (i_r == 4'(rpa_pkg::CORDIC_STEPS - 1)) state_nxt = rpa_pkg::CD_DONE;
      rpa_pkg::CD_DONE: state_nxt = rpa_pkg::CD_IDLE;
      default: state_nxt = rpa_pkg::CD_IDLE;
    endcase
  end

  always_comb begin
    done    = (state_r == rpa_pkg::CD_DONE);
    cos_out = flip_r ? xneg[31:0] : x_r[31:0];
    sin_out = flip_r ? yneg[31:0] : y_r[31:0];
    ang_out = base_r + z_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rpa_pkg::CD_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      rpa_pkg::CD_IDLE: begin
        if (ctl.start) begin
          i_r   <= '0;
          vec_r <= ctl.vec;
          if (ctl.vec) begin
            flip_r <= 1'b0;
            mx_r   <= mx_in;
            if (y_in == '0) begin
              base_r <= '0;
              z_r    <= x_in[49] ? rpa_pkg::HALF_TURN : '0;
            end else if (x_in == '0) begin
              base_r <= '0;
              z_r    <= y_in[49] ? -rpa_pkg::QUARTER_TURN : rpa_pkg::QUARTER_TURN;
            end else if (x_in[49]) begin
              // mirror into the right half plane
              x_r    <= -x_in;
              y_r    <= -y_in;
              z_r    <= '0;
              base_r <= y_in[49] ? -rpa_pkg::HALF_TURN : rpa_pkg::HALF_TURN;
            end else begin
              x_r    <= x_in;
              y_r    <= y_in;
              z_r    <= '0;
              base_r <= '0;
            end
          end else begin
            x_r    <= 50'(rpa_pkg::GAIN_INV);
            y_r    <= '0;
            base_r <= '0;
            if (z1 > rpa_pkg::QUARTER_TURN) begin
              z_r    <= z1 - rpa_pkg::HALF_TURN;
              flip_r <= 1'b1;
            end else if (z1 < -rpa_pkg::QUARTER_TURN) begin
              z_r    <= z1 + rpa_pkg::HALF_TURN;
              flip_r <= 1'b1;
            end else begin
              z_r    <= z1;
              flip_r <= 1'b0;
            end
          end
        end
      end
      rpa_pkg::CD_NORM: begin
        if (norm_lo) begin
          x_r  <= x_r <<< 1;
          y_r  <= y_r <<< 1;
          mx_r <= mx_r <<< 1;
        end else if (norm_hi) begin
          x_r  <= x_r >>> 1;
          y_r  <= y_r >>> 1;
          mx_r <= mx_r >>> 1;
        end
      end
      rpa_pkg::CD_ITER: begin
        i_r <= i_r + 4'd1;
        if (turn_neg) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + tstep;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - tstep;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/rpa_sqdiv.sv -----
// Shared bit-serial unit: floor square root and restoring fraction divide.
`default_nettype none
module rpa_sqdiv (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire rpa_pkg::rpa_sd_ctl_t ctl,
  input  wire logic [63:0] a_in,
  input  wire logic [44:0] den_in,
  output logic             done,
  output logic [31:0]      res_out
);

  rpa_pkg::rpa_sd_state_t state_r, state_nxt;
  logic [63:0] v_r, res_r;
  logic [44:0] den_r;
  logic [4:0]  cnt_r;
  logic        div_r;

  logic [63:0] sbit, trial, r2;
  logic        sq_ge, dv_ge;

  assign sbit  = 64'd1 << {cnt_r, 1'b0};
  assign trial = res_r + sbit;
  assign sq_ge = v_r >= trial;
  assign r2    = {v_r[62:0], 1'b0};
  assign dv_ge = r2 >= {19'd0, den_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rpa_pkg::SD_IDLE: if (ctl.start) state_nxt = rpa_pkg::SD_RUN;
      rpa_pkg::SD_RUN:  if (cnt_r == '0) state_nxt = rpa_pkg::SD_DONE;
      rpa_pkg::SD_DONE: state_nxt = rpa_pkg::SD_IDLE;
      default: state_nxt = rpa_pkg::SD_IDLE;
    endcase
  end

  always_comb begin
    done    = (state_r == rpa_pkg::SD_DONE);
    res_out = res_r[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rpa_pkg::SD_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == rpa_pkg::SD_IDLE && ctl.start) begin
      v_r   <= a_in;
      den_r <= den_in;
      res_r <= '0;
      div_r <= ctl.is_div;
      cnt_r <= ctl.is_div ? 5'd29 : 5'd31;
    end else if (state_r == rpa_pkg::SD_RUN) begin
      cnt_r <= cnt_r - 5'd1;
      if (div_r) begin
        res_r <= {res_r[62:0], dv_ge};
        v_r   <= dv_ge ? r2 - {19'd0, den_r} : r2;
      end else if (sq_ge) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + sbit;
      end else begin
        res_r <= res_r >> 1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/rose_path_two_link_arm_solver.sv -----
// Rose path follower with two-link planar inverse kinematics, top level.
// Usage: each request on the in_ channel (in_valid/in_ready) is one tick.
// in_restart clears the stored phase before the tick is computed. The tick
// yields one result on the out_ channel (out_valid/out_ready): phase after
// advance, shoulder, arm and elbow angles in 1/64 degree, and an out-of-reach
// flag. Registers are written through cfg_we/cfg_index/cfg_data at any edge
// with cfg_we high; write them only while the block is idle.
// Timing: one request at a time; in_ready is high only in the idle state.
// A tick is sequenced through the shared CORDIC unit (three rotations and
// three vectorings of 16 steps plus a one-bit-a-cycle normalize), the shared
// root/divide unit (two 32-step roots and one 30-step divide, skipped when
// the argument clamps) and the shared multiplier.
// The result sits in an output register; the next request is taken while it
// waits, but a finished tick holds until the output register is free, so a
// stalled receiver stalls the block. Synchronous active-low reset clears the
// phase, restores register defaults and drops out_valid.
`default_nettype none
module rose_path_two_link_arm_solver (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_restart,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             out_phase_after,
  output logic signed [15:0]      out_shoulder_angle,
  output logic signed [14:0]      out_arm_angle,
  output logic signed [16:0]      out_elbow_angle,
  output logic                    out_unreachable,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  rpa_pkg::rpa_state_t state_r, state_nxt;

  logic signed [15:0] cx_r, cy_r;
  logic [14:0] l1_r, l2_r, pa_r;
  logic [15:0] ratio_r, step_r, phase_r;

  logic [30:0]        ang_r;
  logic [2:0]         cnt_r;
  logic signed [31:0] c1_r, c2_r, s2_r, amp_r, acs_r, sg_r, cg_r, sn_r, ag_r;
  logic signed [17:0] x_r, y_r;
  logic [34:0]        d2_r;
  logic signed [37:0] num_r;
  logic [25:0]        d_r;
  logic [44:0]        den_r;
  logic [30:0]        q_r, s_r;
  logic               flag_r;
  logic signed [49:0] ex_r, ey_r;

  logic               out_valid_r, out_unreach_r;
  logic [15:0]        out_phase_r;
  logic signed [15:0] out_sg_r;
  logic signed [14:0] out_ag_r;
  logic signed [16:0] out_el_r;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  rpa_pkg::rpa_cd_ctl_t cd_ctl;
  rpa_pkg::rpa_sd_ctl_t sd_ctl;
  logic signed [49:0] cd_x, cd_y;
  logic signed [31:0] cd_z;
  logic               cd_done, sd_done;
  logic signed [31:0] cd_cos, cd_sin, cd_ang;
  logic [63:0]        sd_a;
  logic [31:0]        sd_res;

  logic               in_acc, out_free, finish;
  logic [30:0]        kred_lim;
  logic signed [31:0] th, th_red;
  logic [36:0]        num_abs;
  logic [44:0]        mag;
  logic               mag_gt, mag_eq;
  logic signed [49:0] c_val;
  logic signed [63:0] amp_full, rx_full, ry_full;
  logic [16:0]        p_sum;
  logic [15:0]        p_new;
  logic signed [31:0] sg_o, ag_o;

  rpa_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(mul_p));

  rpa_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .ctl(cd_ctl), .x_in(cd_x), .y_in(cd_y), .z_in(cd_z),
    .done(cd_done), .cos_out(cd_cos), .sin_out(cd_sin), .ang_out(cd_ang)
  );

  rpa_sqdiv u_sqdiv (
    .clk(clk), .rst_n(rst_n), .ctl(sd_ctl), .a_in(sd_a), .den_in(den_r),
    .done(sd_done), .res_out(sd_res)
  );

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign finish   = (state_r == rpa_pkg::ST_DONE) && out_free;
  assign kred_lim = 31'(rpa_pkg::FULL_TURN) << cnt_r;
  assign th       = 32'({phase_r, 10'd0});
  assign th_red   = (th >= rpa_pkg::FULL_TURN) ? th - rpa_pkg::FULL_TURN : th;
  assign num_abs  = num_r[37] ? 37'(-num_r) : num_r[36:0];
  assign mag      = {num_abs, 8'd0};
  assign mag_gt   = mag > den_r;
  assign mag_eq   = mag == den_r;
  assign c_val    = num_r[37] ? -$signed({19'd0, q_r}) : $signed({19'd0, q_r});
  assign amp_full = (mul_p + 64'sd16384) >>> 15;
  assign rx_full  = (mul_p + (64'sd1 <<< 44)) >>> 45;
  assign ry_full  = rx_full;
  assign p_sum    = {1'b0, phase_r} + {1'b0, step_r};
  assign p_new    = (p_sum >= rpa_pkg::PHASE_WRAP) ? '0 : p_sum[15:0];
  assign sg_o     = (sg_r + (32'sd1 <<< (rpa_pkg::ANG_SHIFT - 1))) >>> rpa_pkg::ANG_SHIFT;
  assign ag_o     = (ag_r + (32'sd1 <<< (rpa_pkg::ANG_SHIFT - 1))) >>> rpa_pkg::ANG_SHIFT;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rpa_pkg::ST_IDLE:   if (in_acc) state_nxt = rpa_pkg::ST_KMUL;
      rpa_pkg::ST_KMUL:   state_nxt = rpa_pkg::ST_KRED0;
      rpa_pkg::ST_KRED0:  state_nxt = rpa_pkg::ST_KRED;
      rpa_pkg::ST_KRED:   if (cnt_r == '0) state_nxt = rpa_pkg::ST_TRIG1;
      rpa_pkg::ST_TRIG1:  state_nxt = rpa_pkg::ST_TRIG1W;
      rpa_pkg::ST_TRIG1W: if (cd_done) state_nxt = rpa_pkg::ST_TRIG2;
      rpa_pkg::ST_TRIG2:  state_nxt = rpa_pkg::ST_TRIG2W;
      rpa_pkg::ST_TRIG2W: if (cd_done) state_nxt = rpa_pkg::ST_M_AMP;
      rpa_pkg::ST_M_AMP:  state_nxt = rpa_pkg::ST_M_X;
      rpa_pkg::ST_M_X:    state_nxt = rpa_pkg::ST_M_XC;
      rpa_pkg::ST_M_XC:   state_nxt = rpa_pkg::ST_M_YS;
      rpa_pkg::ST_M_YS:   state_nxt = rpa_pkg::ST_M_XX;
      rpa_pkg::ST_M_XX:   state_nxt = rpa_pkg::ST_M_YY;
      rpa_pkg::ST_M_YY:   state_nxt = rpa_pkg::ST_M_L1;
      rpa_pkg::ST_M_L1:   state_nxt = rpa_pkg::ST_M_L2;
      rpa_pkg::ST_M_L2:   state_nxt = rpa_pkg::ST_SQ1;
      rpa_pkg::ST_SQ1:    state_nxt = rpa_pkg::ST_SQ1W;
      rpa_pkg::ST_SQ1W:   if (sd_done) state_nxt = rpa_pkg::ST_M_DEN;
      rpa_pkg::ST_M_DEN:  state_nxt = rpa_pkg::ST_DEN;
      rpa_pkg::ST_DEN:    state_nxt = rpa_pkg::ST_CMP;
      rpa_pkg::ST_CMP:    state_nxt = (mag_gt || mag_eq) ? rpa_pkg::ST_M_QQ : rpa_pkg::ST_DIVW;
      rpa_pkg::ST_DIVW:   if (sd_done) state_nxt = rpa_pkg::ST_M_QQ;
      rpa_pkg::ST_M_QQ:   state_nxt = rpa_pkg::ST_SQ2;
      rpa_pkg::ST_SQ2:    state_nxt = rpa_pkg::ST_SQ2W;
      rpa_pkg::ST_SQ2W:   if (sd_done) state_nxt = rpa_pkg::ST_AT1;
      rpa_pkg::ST_AT1:    state_nxt = rpa_pkg::ST_AT1W;
      rpa_pkg::ST_AT1W:   if (cd_done) state_nxt = rpa_pkg::ST_AT2;
      rpa_pkg::ST_AT2:    state_nxt = rpa_pkg::ST_AT2W;
      rpa_pkg::ST_AT2W:   if (cd_done) state_nxt = rpa_pkg::ST_TRIG3;
      rpa_pkg::ST_TRIG3:  state_nxt = rpa_pkg::ST_TRIG3W;
      rpa_pkg::ST_TRIG3W: if (cd_done) state_nxt = rpa_pkg::ST_M_EX;
      rpa_pkg::ST_M_EX:   state_nxt = rpa_pkg::ST_M_EY;
      rpa_pkg::ST_M_EY:   state_nxt = rpa_pkg::ST_EYC;
      rpa_pkg::ST_EYC:    state_nxt = rpa_pkg::ST_AT3;
      rpa_pkg::ST_AT3:    state_nxt = rpa_pkg::ST_AT3W;
      rpa_pkg::ST_AT3W:   if (cd_done) state_nxt = rpa_pkg::ST_DONE;
      rpa_pkg::ST_DONE:   if (out_free) state_nxt = rpa_pkg::ST_IDLE;
      default: state_nxt = rpa_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: unit starts and operand selection
  always_comb begin
    in_ready = (state_r == rpa_pkg::ST_IDLE);
    mul_a    = '0;
    mul_b    = '0;
    cd_ctl   = '0;
    sd_ctl   = '0;
    cd_x     = '0;
    cd_y     = '0;
    cd_z     = '0;
    sd_a     = '0;
    unique case (state_r)
      rpa_pkg::ST_KMUL: begin
        mul_a = $signed({16'd0, ratio_r});
        mul_b = $signed({16'd0, phase_r});
      end
      rpa_pkg::ST_TRIG1: begin
        cd_ctl.start = 1'b1;
        cd_z = $signed({1'b0, ang_r});
      end
      rpa_pkg::ST_TRIG2: begin
        cd_ctl.start = 1'b1;
        cd_z = th_red;
      end
      rpa_pkg::ST_M_AMP: begin
        mul_a = $signed({17'd0, pa_r});
        mul_b = c1_r;
      end
      rpa_pkg::ST_M_XC: begin
        mul_a = amp_r;
        mul_b = c2_r;
      end
      rpa_pkg::ST_M_YS: begin
        mul_a = amp_r;
        mul_b = s2_r;
      end
      rpa_pkg::ST_M_XX: begin
        mul_a = 32'(x_r);
        mul_b = 32'(x_r);
      end
      rpa_pkg::ST_M_YY: begin
        mul_a = 32'(y_r);
        mul_b = 32'(y_r);
      end
      rpa_pkg::ST_M_L1: begin
        mul_a = $signed({17'd0, l1_r});
        mul_b = $signed({17'd0, l1_r});
      end
      rpa_pkg::ST_M_L2: begin
        mul_a = $signed({17'd0, l2_r});
        mul_b = $signed({17'd0, l2_r});
      end
      rpa_pkg::ST_SQ1: begin
        sd_ctl.start = 1'b1;
        sd_a = {13'd0, d2_r, 16'd0};
      end
      rpa_pkg::ST_M_DEN: begin
        mul_a = $signed({17'd0, l1_r});
        mul_b = $signed({6'd0, d_r});
      end
      rpa_pkg::ST_CMP: begin
        sd_ctl.start  = !(mag_gt || mag_eq);
        sd_ctl.is_div = 1'b1;
        sd_a = {19'd0, mag};
      end
      rpa_pkg::ST_M_QQ: begin
        mul_a = $signed({1'b0, q_r});
        mul_b = $signed({1'b0, q_r});
      end
      rpa_pkg::ST_SQ2: begin
        sd_ctl.start = 1'b1;
        sd_a = (64'd1 << 60) - 64'(mul_p);
      end
      rpa_pkg::ST_AT1: begin
        cd_ctl = '{start: 1'b1, vec: 1'b1};
        cd_x = c_val;
        cd_y = $signed({19'd0, s_r});
      end
      rpa_pkg::ST_AT2: begin
        cd_ctl = '{start: 1'b1, vec: 1'b1};
        cd_x = 50'(x_r);
        cd_y = 50'(y_r);
      end
      rpa_pkg::ST_TRIG3: begin
        cd_ctl.start = 1'b1;
        cd_z = sg_r;
      end
      rpa_pkg::ST_M_EX: begin
        mul_a = $signed({17'd0, l1_r});
        mul_b = cg_r;
      end
      rpa_pkg::ST_M_EY: begin
        mul_a = $signed({17'd0, l1_r});
        mul_b = sn_r;
      end
      rpa_pkg::ST_AT3: begin
        cd_ctl = '{start: 1'b1, vec: 1'b1};
        cd_x = ex_r;
        cd_y = ey_r;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rpa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      phase_r     <= '0;
      cx_r        <= 16'sd0;
      cy_r        <= 16'sd2560;
      l1_r        <= 15'd2304;
      l2_r        <= 15'd2048;
      pa_r        <= 15'd1024;
      ratio_r     <= 16'd2048;
      step_r      <= 16'd320;
    end else begin
      state_r <= state_nxt;
      if (finish) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (in_acc && in_restart) phase_r <= '0;
      else if (finish) phase_r <= p_new;
      if (cfg_we) begin
        unique case (cfg_index)
          rpa_pkg::CFG_CENTRE_X:   cx_r    <= cfg_data;
          rpa_pkg::CFG_CENTRE_Y:   cy_r    <= cfg_data;
          rpa_pkg::CFG_UPPER_LINK: l1_r    <= cfg_data[14:0];
          rpa_pkg::CFG_LOWER_LINK: l2_r    <= cfg_data[14:0];
          rpa_pkg::CFG_PETAL_AMP:  pa_r    <= cfg_data[14:0];
          rpa_pkg::CFG_PETAL_K:    ratio_r <= cfg_data;
          rpa_pkg::CFG_PHASE_STEP: step_r  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      rpa_pkg::ST_KRED0: begin
        ang_r <= 31'(mul_p >>> rpa_pkg::KTH_SHIFT);
        cnt_r <= 3'd5;
      end
      rpa_pkg::ST_KRED: begin
        if (ang_r >= kred_lim) ang_r <= ang_r - kred_lim;
        cnt_r <= cnt_r - 3'd1;
      end
      rpa_pkg::ST_TRIG1W: if (cd_done) c1_r <= cd_cos;
      rpa_pkg::ST_TRIG2W: begin
        if (cd_done) begin
          c2_r <= cd_cos;
          s2_r <= cd_sin;
        end
      end
      rpa_pkg::ST_M_X:  amp_r <= amp_full[31:0];
      rpa_pkg::ST_M_YS: x_r <= 18'(cx_r) + rx_full[17:0];
      rpa_pkg::ST_M_XX: y_r <= 18'(cy_r) + ry_full[17:0];
      rpa_pkg::ST_M_YY: d2_r <= mul_p[34:0];
      rpa_pkg::ST_M_L1: d2_r <= d2_r + mul_p[34:0];
      rpa_pkg::ST_M_L2: num_r <= $signed({3'd0, d2_r}) + mul_p[37:0];
      rpa_pkg::ST_SQ1:  num_r <= num_r - mul_p[37:0];
      rpa_pkg::ST_SQ1W: if (sd_done) d_r <= sd_res[25:0];
      rpa_pkg::ST_DEN:  den_r <= {mul_p[43:0], 1'b0};
      rpa_pkg::ST_CMP: begin
        // clamp when out of reach; exact unit magnitude is not flagged
        flag_r <= mag_gt;
        q_r    <= rpa_pkg::ONE_Q30;
      end
      rpa_pkg::ST_DIVW: if (sd_done) q_r <= sd_res[30:0];
      rpa_pkg::ST_SQ2W: if (sd_done) s_r <= sd_res[30:0];
      rpa_pkg::ST_AT1W: if (cd_done) acs_r <= cd_ang;
      rpa_pkg::ST_AT2W: if (cd_done) sg_r <= acs_r + cd_ang;
      rpa_pkg::ST_TRIG3W: begin
        if (cd_done) begin
          cg_r <= cd_cos;
          sn_r <= cd_sin;
        end
      end
      rpa_pkg::ST_M_EY: ex_r <= (50'(x_r) <<< 30) - mul_p[49:0];
      rpa_pkg::ST_EYC:  ey_r <= (50'(y_r) <<< 30) - mul_p[49:0];
      rpa_pkg::ST_AT3W: if (cd_done) ag_r <= cd_ang;
      default: begin
      end
    endcase
    if (finish) begin
      out_phase_r   <= p_new;
      out_sg_r      <= sg_o[15:0];
      out_ag_r      <= ag_o[14:0];
      out_el_r      <= ag_o[16:0] - sg_o[16:0];
      out_unreach_r <= flag_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_phase_after    = out_phase_r;
  assign out_shoulder_angle = out_sg_r;
  assign out_arm_angle      = out_ag_r;
  assign out_elbow_angle    = out_el_r;
  assign out_unreachable    = out_unreach_r;

endmodule
`default_nettype wire

// ----- bench/rpa_tick_checker.sv -----
// Checker for the rose path arm solver: predicts each tick and compares results.
`timescale 1ns / 100ps
module rpa_tick_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic               in_restart,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic [15:0]        out_phase_after,
  input  wire logic signed [15:0] out_shoulder_angle,
  input  wire logic signed [14:0] out_arm_angle,
  input  wire logic signed [16:0] out_elbow_angle,
  input  wire logic               out_unreachable,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  output int                      mismatches,
  output int                      pending
);

  typedef struct {
    logic [15:0]        phase_after;
    logic signed [15:0] shoulder;
    logic signed [14:0] arm;
    logic signed [16:0] elbow;
    logic               unreachable;
  } arm_pose_t;

  localparam longint FULL_L    = longint'(rpa_pkg::FULL_TURN);
  localparam longint HALF_L    = longint'(rpa_pkg::HALF_TURN);
  localparam longint QUARTER_L = longint'(rpa_pkg::QUARTER_TURN);
  localparam longint Q30       = 64'sd1073741824;

  longint      cx_q, cy_q;
  int unsigned l1_q, l2_q, amp_q, k_q, step_q, phase_q;
  arm_pose_t   pose_fifo[$];

  function automatic longint arctan_of_step(int i);
    return longint'(rpa_pkg::atan_step(4'(i)));
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // cosine and sine in Q30 of an angle in 2^-16 degree
  task automatic rotate_unit(input longint a, output longint co, output longint si);
    longint x, y, z, nx;
    bit flip;
    x = longint'(rpa_pkg::GAIN_INV);
    y = 0;
    flip = 0;
    z = a % FULL_L;
    if (z < 0) z += FULL_L;
    if (z > HALF_L) z -= FULL_L;
    if (z > QUARTER_L) begin
      z -= HALF_L;
      flip = 1;
    end else if (z < -QUARTER_L) begin
      z += HALF_L;
      flip = 1;
    end
    for (int i = 0; i < rpa_pkg::CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= arctan_of_step(i);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += arctan_of_step(i);
      end
      x = nx;
    end
    co = flip ? -x : x;
    si = flip ? -y : y;
  endtask

  function automatic longint heading(longint y, longint x);
    longint base_a, z, nx;
    longint unsigned ax, ay, mx;
    base_a = 0;
    z = 0;
    if (y == 0) return (x >= 0) ? 64'sd0 : HALF_L;
    if (x == 0) return (y > 0) ? QUARTER_L : -QUARTER_L;
    if (x < 0) begin
      x = -x;
      y = -y;
      base_a = (y < 0) ? HALF_L : -HALF_L;
    end
    ax = x;
    ay = (y < 0) ? -y : y;
    mx = (ax > ay) ? ax : ay;
    while (mx < (64'd1 << 30)) begin
      x = x * 2;
      y = y * 2;
      mx = mx << 1;
    end
    while (mx >= (64'd1 << 31)) begin
      x = x >>> 1;
      y = y >>> 1;
      mx = mx >> 1;
    end
    for (int i = 0; i < rpa_pkg::CORDIC_STEPS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += arctan_of_step(i);
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= arctan_of_step(i);
      end
      x = nx;
    end
    return base_a + z;
  endfunction

  task automatic solve_tick(input bit restart, output arm_pose_t p);
    longint th, kth, c1, s1, c2, s2, amp, x, y, num, den, c, acs, sg, ag;
    longint cg, sgn, ex, ey, sg_o, ag_o, l1;
    longint unsigned d2, d, r, q, mag, kprod;
    int unsigned nxt;
    bit flag;
    flag = 0;
    if (restart) phase_q = 0;
    th = longint'(phase_q) << rpa_pkg::ANG_SHIFT;
    kprod = (longint'(k_q) * longint'(phase_q)) << 16;
    kth = longint'((kprod >> (12 + rpa_pkg::ANGLE_FRAC_BITS)) % 64'd23592960);
    rotate_unit(kth, c1, s1);
    rotate_unit(th, c2, s2);
    amp = rnd_shift(longint'(amp_q) * c1, 15);
    x = cx_q + rnd_shift(amp * c2, 45);
    y = cy_q + rnd_shift(amp * s2, 45);
    l1 = longint'(l1_q);
    d2 = x * x + y * y;
    num = longint'(d2) + l1 * l1 - longint'(l2_q) * longint'(l2_q);
    d = int_sqrt(d2 << 16);
    den = 2 * l1 * longint'(d);
    mag = (num < 0) ? -num : num;
    mag = mag << 8;
    if (mag > den) begin
      flag = 1;
      q = Q30;
    end else if (mag == den) begin
      q = Q30;
    end else begin
      r = mag;
      q = 0;
      for (int i = 0; i < 30; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q = q | 64'd1;
        end
      end
    end
    c = (num < 0) ? -longint'(q) : longint'(q);
    acs = heading(longint'(int_sqrt(Q30 * Q30 - c * c)), c);
    sg = acs + heading(y, x);
    rotate_unit(sg, cg, sgn);
    ex = x * Q30 - l1 * cg;
    ey = y * Q30 - l1 * sgn;
    ag = heading(ey, ex);
    sg_o = rnd_shift(sg, rpa_pkg::ANG_SHIFT);
    ag_o = rnd_shift(ag, rpa_pkg::ANG_SHIFT);
    nxt = phase_q + step_q;
    if (nxt >= 32'(rpa_pkg::PHASE_WRAP)) nxt = 0;
    phase_q = nxt & 32'hFFFF;
    p.phase_after = phase_q[15:0];
    p.shoulder    = sg_o[15:0];
    p.arm         = ag_o[14:0];
    p.elbow       = 17'(ag_o - sg_o);
    p.unreachable = flag;
  endtask

  assign pending = pose_fifo.size();

  always @(posedge clk) begin
    arm_pose_t want, got;
    if (!rst_n) begin
      cx_q = 0;
      cy_q = 2560;
      l1_q = 2304;
      l2_q = 2048;
      amp_q = 1024;
      k_q = 2048;
      step_q = 320;
      phase_q = 0;
      pose_fifo.delete();
      mismatches <= 0;
    end else begin
      if (cfg_we) begin
        case (rpa_pkg::rpa_cfg_idx_t'(cfg_index))
          rpa_pkg::CFG_CENTRE_X:   cx_q = longint'($signed(cfg_data));
          rpa_pkg::CFG_CENTRE_Y:   cy_q = longint'($signed(cfg_data));
          rpa_pkg::CFG_UPPER_LINK: l1_q = cfg_data[14:0];
          rpa_pkg::CFG_LOWER_LINK: l2_q = cfg_data[14:0];
          rpa_pkg::CFG_PETAL_AMP:  amp_q = cfg_data[14:0];
          rpa_pkg::CFG_PETAL_K:    k_q = cfg_data;
          rpa_pkg::CFG_PHASE_STEP: step_q = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        solve_tick(in_restart, want);
        pose_fifo.push_back(want);
      end
      if (out_valid && out_ready) begin
        got.phase_after = out_phase_after;
        got.shoulder    = out_shoulder_angle;
        got.arm         = out_arm_angle;
        got.elbow       = out_elbow_angle;
        got.unreachable = out_unreachable;
        if (pose_fifo.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result phase=%0d", $realtime, got.phase_after);
          mismatches <= mismatches + 1;
        end else begin
          want = pose_fifo.pop_front();
          if (got.phase_after !== want.phase_after || got.shoulder !== want.shoulder ||
              got.arm !== want.arm || got.elbow !== want.elbow ||
              got.unreachable !== want.unreachable) begin
            if (mismatches < 10)
              $display("%0t: mismatch exp ph=%0d sh=%0d arm=%0d elb=%0d unr=%0b got ph=%0d sh=%0d arm=%0d elb=%0d unr=%0b",
                       $realtime, want.phase_after, want.shoulder, want.arm, want.elbow,
                       want.unreachable, got.phase_after, got.shoulder, got.arm, got.elbow,
                       got.unreachable);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

// ----- bench/tb_rose_path_two_link_arm_solver.sv -----
// Stimulus and verdict for the rose path two-link arm solver.
`timescale 1ns / 100ps
module tb_rose_path_two_link_arm_solver;

  localparam int          CYCLE_LIMIT  = 1500000;
  localparam int          SETTLE_TICKS = 400;
  localparam int          HOLD_AT      = 400;
  localparam logic [2:0]  CFG_SPARE    = 3'd7;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_ready;
  logic               in_restart = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic [15:0]        out_phase_after;
  logic signed [15:0] out_shoulder_angle;
  logic signed [14:0] out_arm_angle;
  logic signed [16:0] out_elbow_angle;
  logic               out_unreachable;
  logic               cfg_we = 0;
  logic [2:0]         cfg_index = 0;
  logic [15:0]        cfg_data = 0;
  int                 mismatches, pending;
  int                 cycles = 0;
  int                 sent = 0;
  bit                 calm = 0;
  bit                 long_hold_req = 0;
  int                 hold_left = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  rose_path_two_link_arm_solver DUT (.*);

  rpa_tick_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  always @(negedge clk) begin
    if (long_hold_req && hold_left == 0) begin
      long_hold_req = 0;
      hold_left = 1500;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready = 0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      hold_left = $urandom_range(1, 7);
      out_ready = 0;
    end else begin
      out_ready = 1;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic send_tick(input bit restart);
    if (!calm && $urandom_range(0, 4) == 0) repeat ($urandom_range(1, 7)) @(negedge clk);
    in_valid = 1;
    in_restart = restart;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 0;
    sent = sent + 1;
    // hold off the receiver mid-phase while requests keep coming
    if (sent == HOLD_AT) long_hold_req = 1;
  endtask

  task automatic drain;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  task automatic run_phase(input logic [15:0] cx, input logic [15:0] cy,
                           input logic [15:0] l1, input logic [15:0] l2,
                           input logic [15:0] amp, input logic [15:0] k,
                           input logic [15:0] step, input int n, input int restart_pct);
    drain();
    write_reg(rpa_pkg::CFG_CENTRE_X, cx);
    write_reg(rpa_pkg::CFG_CENTRE_Y, cy);
    write_reg(rpa_pkg::CFG_UPPER_LINK, l1);
    write_reg(rpa_pkg::CFG_LOWER_LINK, l2);
    write_reg(rpa_pkg::CFG_PETAL_AMP, amp);
    write_reg(rpa_pkg::CFG_PETAL_K, k);
    write_reg(rpa_pkg::CFG_PHASE_STEP, step);
    for (int i = 0; i < n; i++) send_tick($urandom_range(0, 99) < restart_pct);
  endtask

  initial begin
    logic [15:0] l1, l2, reach;
    repeat (9) @(negedge clk);
    rst_n = 1;

    // default registers, restart, plain ticks and a write to the unused index
    send_tick(1);
    send_tick(0);
    send_tick(0);
    drain();
    write_reg(CFG_SPARE, 16'hFFFF);
    send_tick(0);
    // target at the shoulder with equal links: zero numerator
    run_phase(16'd0, 16'd0, 16'd2048, 16'd2048, 16'd0, 16'd0, 16'd0, 1, 0);
    // target at the shoulder, unequal links: clamp
    run_phase(16'd0, 16'd0, 16'd2304, 16'd2048, 16'd0, 16'd0, 16'd0, 1, 0);
    // zero upper link
    run_phase(16'd512, 16'd300, 16'd0, 16'd2048, 16'd0, 16'd0, 16'd0, 1, 0);
    // target on negative x axis, then on negative y axis
    run_phase(16'hF800, 16'd0, 16'd2304, 16'd2048, 16'd0, 16'd0, 16'd0, 1, 0);
    run_phase(16'd0, 16'hF800, 16'd2304, 16'd2048, 16'd0, 16'd0, 16'd0, 1, 0);
    // extreme centre and sizes; tiny links far out of reach
    run_phase(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'd46079, 3, 0);
    run_phase(16'h8000, 16'h7FFF, 16'd1, 16'd1, 16'h7FFF, 16'hFFFF, 16'hFFFF, 2, 0);
    // wrap: step of one full turn, and zero step
    run_phase(16'd0, 16'd2560, 16'd2304, 16'd2048, 16'd1024, 16'd4096, 16'd23040, 4, 25);
    run_phase(16'd100, 16'd2000, 16'd2304, 16'd2048, 16'd1024, 16'd2048, 16'd0, 2, 0);

    for (int ph = 0; ph < 17; ph++) begin
      if (ph == 16) calm = 1;
      l1 = 16'($urandom_range(128, 8192));
      l2 = 16'($urandom_range(128, 8192));
      reach = l1 + l2;
      if (ph % 5 == 4)
        run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom_range(0, 65535)), 48, 5);
      else
        run_phase(16'($signed($urandom_range(0, 2 * reach)) - $signed(reach)),
                  16'($signed($urandom_range(0, 2 * reach)) - $signed(reach)),
                  l1, l2, 16'($urandom_range(0, reach / 2)), 16'($urandom),
                  16'($urandom_range(1, 4000)), 48, 5);
    end

    while (pending != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
